@@ rtl/sct_pkg.sv @@
// Shared types, codes and arithmetic helpers for the serial command thermostat.
`timescale 1ns / 1ps
package sct_pkg;

  // Frame header characters
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_O = 8'h4F;
  localparam logic [7:0] CH_M = 8'h4D;

  // Command codes
  localparam logic [3:0] CMD_GROUP   = 4'hA;
  localparam logic [7:0] CMD_SET     = 8'hA0;
  localparam logic [7:0] CMD_UP      = 8'hA1;
  localparam logic [7:0] CMD_DOWN    = 8'hA2;
  localparam logic [7:0] CMD_MODE    = 8'hA3;
  localparam logic [7:0] CMD_DRIVE   = 8'hA6;
  localparam logic [7:0] CMD_RD_TEMP = 8'hA8;
  localparam logic [7:0] CMD_RD_MODE = 8'hAE;

  // Drive codes and reply data
  localparam logic [7:0] DRIVE_HEAT = 8'hC0;
  localparam logic [7:0] DRIVE_COOL = 8'h60;
  localparam logic [7:0] DRIVE_IDLE = 8'h7A;
  localparam logic [7:0] MODE_IDLE  = 8'h7F;
  localparam logic [7:0] MODE_AUTO  = 8'hFF;
  localparam logic [7:0] PAD_ZERO   = 8'h00;
  localparam logic [7:0] PAD_ONES   = 8'hFF;

  localparam logic [6:0] TEMP_MAX = 7'd99;
  localparam logic [2:0] REPLY_LAST = 3'd5;

  typedef enum logic [2:0] {
    POS_C   = 3'd0,
    POS_O   = 3'd1,
    POS_M   = 3'd2,
    POS_CMD = 3'd3,
    POS_D1  = 3'd4,
    POS_D2  = 3'd5
  } frame_pos_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [7:0] adc_sample;
  } in_word_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
    logic [7:0] drive_level;
    logic [3:0] temp_tens;
    logic [3:0] temp_ones;
  } out_word_t;

  typedef struct packed {
    frame_pos_t pos;
    logic [7:0] cmd;
    logic [7:0] d1;
    logic [7:0] target;
    logic       idle;
    logic       tvalid;
    logic [7:0] drive;
    logic [6:0] room;
  } thermo_state_t;

  typedef struct packed {
    logic       reply;
    logic [7:0] code;
    logic [7:0] d1;
    logic [7:0] d2;
  } reply_t;

  // min(x*100/255, 99); divide by 255 as (p + 1 + p/256) / 256, exact for p < 65535
  function automatic logic [6:0] scale_temp(input logic [7:0] x);
    logic [14:0] p;
    logic [15:0] s;
    logic [7:0]  q;
    p = {1'b0, x, 6'b0} + {2'b0, x, 5'b0} + {5'b0, x, 2'b0};
    s = {1'b0, p} + 16'd1 + {9'b0, p[14:8]};
    q = s[15:8];
    if (q > {1'b0, TEMP_MAX}) begin
      return TEMP_MAX;
    end
    return q[6:0];
  endfunction

  // t / 10 for t below 100, via t*205 >> 11
  function automatic logic [3:0] temp_tens(input logic [6:0] t);
    logic [14:0] m;
    m = {8'b0, t} * 15'd205;
    return m[14:11];
  endfunction

  function automatic logic [3:0] temp_ones(input logic [6:0] t);
    logic [3:0] tn;
    logic [6:0] r;
    tn = temp_tens(t);
    r  = t - 7'({tn, 3'b0} + {2'b0, tn, 1'b0});
    return r[3:0];
  endfunction

endpackage

@@ rtl/sct_exec.sv @@
// Frame parser and command executor: next thermostat state and reply for one word.
`timescale 1ns / 1ps
module sct_exec (
  input  sct_pkg::thermo_state_t cur,
  input  sct_pkg::in_word_t      in_word,
  output sct_pkg::thermo_state_t nxt,
  output sct_pkg::reply_t        rep
);
  import sct_pkg::*;

  logic [7:0] b;
  logic [1:0] d2_hundreds;

  assign b = in_word.rx_byte;

  always_comb begin
    priority if (b >= 8'd200) begin
      d2_hundreds = 2'd2;
    end else if (b >= 8'd100) begin
      d2_hundreds = 2'd1;
    end else begin
      d2_hundreds = 2'd0;
    end
  end

  always_comb begin
    nxt = cur;
    rep = '0;
    unique case (cur.pos)
      POS_O: begin
        if (b == CH_O) nxt.pos = POS_M;
      end
      POS_M: begin
        if (b == CH_M) nxt.pos = POS_CMD;
      end
      POS_CMD: begin
        nxt.cmd = b;
        nxt.pos = POS_D1;
      end
      POS_D1: begin
        nxt.d1  = b;
        nxt.pos = POS_D2;
      end
      POS_D2: begin
        nxt.pos  = POS_C;
        nxt.room = scale_temp(in_word.adc_sample);
        if (cur.cmd[7:4] == CMD_GROUP) begin
          unique case (cur.cmd)
            CMD_SET: begin
              nxt.target = cur.d1 + {6'b0, d2_hundreds};
              nxt.tvalid = 1'b1;
            end
            CMD_UP: begin
              nxt.target = cur.target + 8'd1;
              nxt.tvalid = 1'b1;
            end
            CMD_DOWN: begin
              nxt.target = cur.target - 8'd1;
              nxt.tvalid = 1'b1;
            end
            CMD_MODE: begin
              nxt.idle = ~cur.idle;
            end
            CMD_DRIVE: begin
              nxt.drive  = cur.d1;
              nxt.tvalid = 1'b0;
            end
            CMD_RD_TEMP: begin
              rep.reply = 1'b1;
              rep.code  = CMD_RD_TEMP;
              rep.d1    = {1'b0, nxt.room};
              rep.d2    = PAD_ZERO;
            end
            CMD_RD_MODE: begin
              rep.reply = 1'b1;
              rep.code  = CMD_RD_MODE;
              rep.d1    = cur.idle ? MODE_IDLE : MODE_AUTO;
              rep.d2    = PAD_ONES;
            end
            default: begin
            end
          endcase
        end
        // drive update after every completed frame, when idle or a target is valid
        if (nxt.idle) begin
          nxt.drive = DRIVE_IDLE;
        end else if (nxt.tvalid) begin
          nxt.drive = (nxt.target > {1'b0, nxt.room}) ? DRIVE_HEAT : DRIVE_COOL;
        end
      end
      default: begin
        nxt.pos = (b == CH_C) ? POS_O : POS_C;
      end
    endcase
  end

endmodule

@@ rtl/serial_command_thermostat_top.sv @@
// Serial command thermostat top level: state register, executor and reply sequencer.
// Latency: a word's first result is presented the cycle after it is accepted.
// Throughput: one word per cycle if no reply is due and out_ready is high; a reply
// frame blocks input until all six bytes leave, one per cycle with out_ready high.
// Reset (rst, synchronous): header hunt restarts, idle mode, drive 0x7A, no target.
`timescale 1ns / 1ps
module serial_command_thermostat_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sct_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sct_pkg::out_word_t out_data
);
  import sct_pkg::*;

  // Thermostat state, updated at the edge where a word is accepted
  thermo_state_t st;
  thermo_state_t st_next;
  reply_t        rep;

  // Result register: one entry describes every result item of the last word
  logic       res_valid;
  logic       res_reply;
  logic [2:0] idx;
  logic [7:0] res_code;
  logic [7:0] res_d1;
  logic [7:0] res_d2;
  logic [7:0] res_drive;
  logic [3:0] res_tens;
  logic [3:0] res_ones;

  logic in_fire;
  logic out_fire;
  logic item_last;

  sct_exec u_exec (
    .cur     (st),
    .in_word (in_data),
    .nxt     (st_next),
    .rep     (rep)
  );

  assign item_last = ~res_reply | (idx == REPLY_LAST);
  assign out_fire  = out_valid & out_ready;
  // Take a new word when the result register is empty or its final item leaves now
  assign in_ready  = ~res_valid | (out_ready & item_last);
  assign in_fire   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.pos    <= POS_C;
      st.cmd    <= '0;
      st.d1     <= '0;
      st.target <= '0;
      st.idle   <= 1'b1;
      st.tvalid <= 1'b0;
      st.drive  <= DRIVE_IDLE;
      st.room   <= '0;
    end else if (in_fire) begin
      st <= st_next;
    end
  end

  // Hold the result until its last item is taken; advance one reply byte per take
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      res_reply <= 1'b0;
      idx       <= '0;
    end else if (in_fire) begin
      res_valid <= 1'b1;
      res_reply <= rep.reply;
      idx       <= '0;
    end else if (out_fire) begin
      if (item_last) begin
        res_valid <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  // Payload of the result register: no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_code  <= rep.code;
      res_d1    <= rep.d1;
      res_d2    <= rep.d2;
      res_drive <= st_next.drive;
      res_tens  <= temp_tens(st_next.room);
      res_ones  <= temp_ones(st_next.room);
    end
  end

  // Output word: reply bytes go out as C, O, M, code, data1, data2
  always_comb begin
    out_data             = '0;
    out_data.tx_valid    = res_reply;
    out_data.last        = item_last;
    out_data.drive_level = res_drive;
    out_data.temp_tens   = res_tens;
    out_data.temp_ones   = res_ones;
    if (res_reply) begin
      unique case (idx)
        3'd0:    out_data.tx_byte = CH_C;
        3'd1:    out_data.tx_byte = CH_O;
        3'd2:    out_data.tx_byte = CH_M;
        3'd3:    out_data.tx_byte = res_code;
        3'd4:    out_data.tx_byte = res_d1;
        3'd5:    out_data.tx_byte = res_d2;
        default: out_data.tx_byte = '0;
      endcase
    end
  end

  assign out_valid = res_valid;

  // Sequencer index stays within the six reply bytes
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (idx <= REPLY_LAST))
    else $error("reply index out of range");

  // A result without reply is a single item
  a_noreply_idx: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_reply) |-> (idx == 3'd0))
    else $error("non-reply result advanced its index");

  // A taken reply byte that is not the last advances the sequencer by one
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (out_fire && !item_last && !in_fire) |=> (res_valid && idx == $past(idx) + 3'd1))
    else $error("reply sequencer did not advance");

  // Idle mode always leaves the idle drive code
  a_idle_drive: assert property (@(posedge clk) disable iff (rst)
    st.idle |-> (st.drive == DRIVE_IDLE))
    else $error("idle mode with non-idle drive");

endmodule
